/* rtl/core/ibmw_pkg.sv */
// ----------------------------------------------------------------------------
// ibmw_pkg: shared types and constants of the indirect block map walker
// Field widths, status and kind codes, controller states and the range
// thresholds of the three indirect levels for each supported block size.
// ----------------------------------------------------------------------------
package ibmw_pkg;

  // field widths
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned IDX_W       = 32;
  localparam int unsigned BN_W        = 32;
  localparam int unsigned WIDX_W      = 10;
  localparam int unsigned OFS_W       = 20;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned S_TDATA_W   = 104;
  localparam int unsigned M_TDATA_W   = 48;

  // inode pointer layout
  localparam int unsigned DIRECT_SLOTS = 12;
  localparam int unsigned SLOT_COUNT   = 15;
  localparam logic [SLOT_W-1:0] SLOT_SINGLE = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_DOUBLE = 4'd13;
  localparam logic [SLOT_W-1:0] SLOT_TRIPLE = 4'd14;

  // supported pointers-per-block exponents
  localparam logic [CFG_W-1:0] LOG2_MIN   = 4'd8;
  localparam logic [CFG_W-1:0] LOG2_MID   = 4'd9;
  localparam logic [CFG_W-1:0] LOG2_MAX   = 4'd10;
  localparam logic [CFG_W-1:0] LOG2_RESET = 4'd8;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_REQUEST  = 3'd0,
    ST_MAPPED   = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FAILED   = 3'd3,
    ST_PROTOCOL = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_EXEC = 3'b010,
    CS_OUT  = 3'b100
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       has_result;
    logic       busy;
    logic [1:0] levels;
  } dp_stat_t;

  // upper bounds (exclusive) of the single, double and triple ranges
  typedef struct packed {
    logic [IDX_W-1:0] t1;
    logic [IDX_W-1:0] t2;
    logic [IDX_W-1:0] t3;
  } thresh_t;

  function automatic thresh_t range_bounds(input logic [CFG_W-1:0] l);
    thresh_t r;
    case (l)
      LOG2_MID: begin
        r.t1 = 32'(DIRECT_SLOTS + 2**9);
        r.t2 = 32'(DIRECT_SLOTS + 2**9 + 2**18);
        r.t3 = 32'(DIRECT_SLOTS + 2**9 + 2**18 + 2**27);
      end
      LOG2_MAX: begin
        r.t1 = 32'(DIRECT_SLOTS + 2**10);
        r.t2 = 32'(DIRECT_SLOTS + 2**10 + 2**20);
        r.t3 = 32'(DIRECT_SLOTS + 2**10 + 2**20 + 2**30);
      end
      default: begin
        r.t1 = 32'(DIRECT_SLOTS + 2**8);
        r.t2 = 32'(DIRECT_SLOTS + 2**8 + 2**16);
        r.t3 = 32'(DIRECT_SLOTS + 2**8 + 2**16 + 2**24);
      end
    endcase
    return r;
  endfunction

  // low-bit mask of one level's word index
  function automatic logic [WIDX_W-1:0] level_mask(input logic [CFG_W-1:0] l);
    logic [WIDX_W-1:0] m;
    case (l)
      LOG2_MID: m = 10'h1ff;
      LOG2_MAX: m = 10'h3ff;
      default:  m = 10'h0ff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/ibmw_ctrl.sv */
// ----------------------------------------------------------------------------
// ibmw_ctrl: sequencing controller
// Takes one item, lets the datapath process it, then holds the result, if
// the item has one, until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module ibmw_ctrl import ibmw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_EXEC;
      end
      CS_EXEC: begin
        state_d = stat_i.has_result ? CS_OUT : CS_IDLE;
      end
      CS_OUT: begin
        if (out_ready_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshakes and commands
  assign in_ready_o    = (state_q == CS_IDLE);
  assign out_valid_o   = (state_q == CS_OUT);
  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.execute = (state_q == CS_EXEC);

endmodule

/* rtl/core/ibmw_datapath.sv */
// ----------------------------------------------------------------------------
// ibmw_datapath: pointer store, walk state and result register
// Classifies a lookup against the level bounds, steps the walk on
// returned words and loads inode pointer slots.
// ----------------------------------------------------------------------------
module ibmw_datapath import ibmw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  kind_e             kind_i,
  input  logic [IDX_W-1:0]  logical_index_i,
  input  logic [BN_W-1:0]   read_word_i,
  input  logic              read_error_i,
  input  logic [SLOT_W-1:0] pointer_slot_i,
  input  logic [BN_W-1:0]   pointer_value_i,
  output status_e           status_o,
  output logic [BN_W-1:0]   block_number_o,
  output logic [WIDX_W-1:0] word_index_o
);

  // configuration and walk state
  logic [CFG_W-1:0] wpb_log2_q;
  logic             busy_q, busy_d;
  logic [1:0]       levels_q, levels_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;

  // captured item
  kind_e             kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [BN_W-1:0]   rword_q;
  logic              rerr_q;
  logic [SLOT_W-1:0] slot_q;
  logic [BN_W-1:0]   pval_q;

  // pointer store and result
  logic [BN_W-1:0]   ptr_q [SLOT_COUNT];
  status_e           res_status_q, res_status_d;
  logic [BN_W-1:0]   res_block_q, res_block_d;
  logic [WIDX_W-1:0] res_word_q, res_word_d;
  logic              has_result;
  logic              ptr_we;

  // derived values
  logic [CFG_W-1:0]  l;
  logic [WIDX_W-1:0] lmask;
  thresh_t           bnd;
  logic [SLOT_W-1:0] rd_slot;
  logic [BN_W-1:0]   ptr_rd;
  logic [IDX_W-1:0]  d1, d2, d3;
  logic [IDX_W-1:0]  d2_sh, d3_sh;
  logic [4:0]        l2;
  logic              in_direct, in_single, in_double, in_triple;
  logic [OFS_W-1:0]  ofs_sh;
  logic [CFG_W-1:0]  walk_shift;

  // clamp the block size exponent
  always_comb begin
    if (wpb_log2_q < LOG2_MIN)      l = LOG2_MIN;
    else if (wpb_log2_q > LOG2_MAX) l = LOG2_MAX;
    else                            l = wpb_log2_q;
  end

  assign lmask = level_mask(l);
  assign bnd   = range_bounds(l);
  assign l2    = {l, 1'b0};

  // range classification, compares run side by side
  assign in_direct = idx_q < IDX_W'(DIRECT_SLOTS);
  assign in_single = idx_q < bnd.t1;
  assign in_double = idx_q < bnd.t2;
  assign in_triple = idx_q < bnd.t3;

  assign d1    = idx_q - IDX_W'(DIRECT_SLOTS);
  assign d2    = idx_q - bnd.t1;
  assign d3    = idx_q - bnd.t2;
  assign d2_sh = d2 >> l;
  assign d3_sh = d3 >> l2;

  // pointer slot for the lookup
  always_comb begin
    if (in_direct)      rd_slot = idx_q[SLOT_W-1:0];
    else if (in_single) rd_slot = SLOT_SINGLE;
    else if (in_double) rd_slot = SLOT_DOUBLE;
    else                rd_slot = SLOT_TRIPLE;
  end

  always_comb begin
    if (rd_slot <= SLOT_TRIPLE) ptr_rd = ptr_q[rd_slot];
    else                        ptr_rd = '0;
  end

  // walk step on a returned word
  assign walk_shift = (levels_q == 2'd2) ? l : '0;
  assign ofs_sh     = ofs_q >> walk_shift;

  // item processing
  always_comb begin
    busy_d       = busy_q;
    levels_d     = levels_q;
    ofs_d        = ofs_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    res_word_d   = res_word_q;
    has_result   = 1'b0;
    ptr_we       = 1'b0;
    case (kind_q)
      KIND_LOOKUP: begin
        has_result   = 1'b1;
        res_block_d  = '0;
        res_word_d   = '0;
        if (busy_q) begin
          res_status_d = ST_PROTOCOL;
        end else if (in_direct) begin
          res_status_d = ST_MAPPED;
          res_block_d  = ptr_rd;
        end else if (in_single) begin
          res_status_d = ST_REQUEST;
          res_block_d  = ptr_rd;
          res_word_d   = d1[WIDX_W-1:0];
          busy_d       = 1'b1;
          levels_d     = 2'd0;
          ofs_d        = '0;
        end else if (in_double) begin
          res_status_d = ST_REQUEST;
          res_block_d  = ptr_rd;
          res_word_d   = d2_sh[WIDX_W-1:0];
          busy_d       = 1'b1;
          levels_d     = 2'd1;
          ofs_d        = {{(OFS_W-WIDX_W){1'b0}}, d2[WIDX_W-1:0] & lmask};
        end else if (in_triple) begin
          res_status_d = ST_REQUEST;
          res_block_d  = ptr_rd;
          res_word_d   = d3_sh[WIDX_W-1:0];
          busy_d       = 1'b1;
          levels_d     = 2'd2;
          ofs_d        = OFS_W'(d3[OFS_W-1:0] & ~({OFS_W{1'b1}} << l2));
        end else begin
          res_status_d = ST_RANGE;
        end
      end
      KIND_DATA: begin
        has_result  = 1'b1;
        res_block_d = '0;
        res_word_d  = '0;
        if (!busy_q) begin
          res_status_d = ST_PROTOCOL;
        end else if (rerr_q) begin
          res_status_d = ST_FAILED;
          busy_d       = 1'b0;
          levels_d     = 2'd0;
          ofs_d        = '0;
        end else if (levels_q == 2'd0) begin
          res_status_d = ST_MAPPED;
          res_block_d  = rword_q;
          busy_d       = 1'b0;
          ofs_d        = '0;
        end else begin
          res_status_d = ST_REQUEST;
          res_block_d  = rword_q;
          res_word_d   = ofs_sh[WIDX_W-1:0] & lmask;
          ofs_d        = (levels_q == 2'd2) ?
                         (ofs_q & {{(OFS_W-WIDX_W){1'b0}}, lmask}) : '0;
          levels_d     = levels_q - 2'd1;
        end
      end
      KIND_LOAD: begin
        ptr_we = (slot_q <= SLOT_TRIPLE);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpb_log2_q <= LOG2_RESET;
      busy_q     <= 1'b0;
      levels_q   <= 2'd0;
      ofs_q      <= '0;
    end else begin
      if (cfg_we_i) wpb_log2_q <= cfg_data_i;
      if (cmd_i.execute) begin
        busy_q   <= busy_d;
        levels_q <= levels_d;
        ofs_q    <= ofs_d;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      idx_q   <= logical_index_i;
      rword_q <= read_word_i;
      rerr_q  <= read_error_i;
      slot_q  <= pointer_slot_i;
      pval_q  <= pointer_value_i;
    end
  end

  // result register and pointer store
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_block_q  <= res_block_d;
      res_word_q   <= res_word_d;
      if (ptr_we) ptr_q[slot_q] <= pval_q;
    end
  end

  assign stat_o.has_result = has_result;
  assign stat_o.busy       = busy_q;
  assign stat_o.levels     = levels_q;
  assign status_o          = res_status_q;
  assign block_number_o    = res_block_q;
  assign word_index_o      = res_word_q;

endmodule

/* rtl/core/indirect_block_map_walker.sv */
// ----------------------------------------------------------------------------
// indirect_block_map_walker: logical to disk block mapping through inode
// pointers with single, double and triple indirect levels
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one item per transfer; tuser is the kind (lookup,
//   returned read data, pointer load), tdata the remaining fields.
// - m_axis carries zero or one result per item; tuser is the status,
//   tdata the block number and word index. A read request on m_axis is
//   answered by a data item on s_axis once the word has been read.
// - cfg_* writes log2 of pointers per block; write it only while idle.
// - One item is handled at a time: accept, processing in the datapath,
//   then the result register. The controller's three-state sequence
//   (idle, execute, output) steps each item; an item without a result
//   returns from execute to idle and skips the output state.
// - While the receiver stalls, the result holds and s_axis_tready stays
//   low. Reset clears the walk, returns to idle and sets the block size
//   exponent to 8; inode pointers are undefined until loaded.
// ----------------------------------------------------------------------------
module indirect_block_map_walker import ibmw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] logical_index, [63:32] read_word, [64] read_error,
  // [68:65] pointer_slot, [100:69] pointer_value, [103:101] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]           s_axis_tuser,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] block_number, [41:32] word_index, [47:42] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]           m_axis_tuser
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  status_e           status;
  logic [BN_W-1:0]   block_number;
  logic [WIDX_W-1:0] word_index;

  // config always taken
  assign cfg_ready_o = 1'b1;

  ibmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ibmw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (kind_e'(s_axis_tuser)),
    .logical_index_i (s_axis_tdata[31:0]),
    .read_word_i     (s_axis_tdata[63:32]),
    .read_error_i    (s_axis_tdata[64]),
    .pointer_slot_i  (s_axis_tdata[68:65]),
    .pointer_value_i (s_axis_tdata[100:69]),
    .status_o        (status),
    .block_number_o  (block_number),
    .word_index_o    (word_index)
  );

  // output packing
  assign m_axis_tdata = {{(M_TDATA_W-BN_W-WIDX_W){1'b0}}, word_index, block_number};
  assign m_axis_tuser = status;

  // one item at a time: never ready while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // an accepted item closes the input for the next cycle
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready after accept");

  // pending levels only during a walk
  a_levels_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.busy |-> (stat.levels == 2'd0))
    else $error("levels left without a walk");

  // only read requests carry a word index
  a_word_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_REQUEST)) |-> (m_axis_tdata[41:32] == '0))
    else $error("word index on a non-request result");

endmodule

/* dv/indirect_block_map_walker_tb.sv */
// ----------------------------------------------------------------------------
// indirect_block_map_walker_tb: self-checking bench of the block map walker
// Loads all inode pointer slots, then runs directed and random lookups with
// their indirect reads over every block size setting. Each accepted item is
// predicted in the bench, and every result transfer is checked field by field.
// ----------------------------------------------------------------------------
module indirect_block_map_walker_tb;
  import ibmw_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  // block size exponents written after the reset-default phase
  localparam logic [CFG_W-1:0] BLOCK_EXPS [7] = '{
    LOG2_MAX, LOG2_MID, 4'd0, 4'd15, LOG2_MIN, 4'd7, 4'd11
  };

  typedef enum int unsigned {
    SPAN_DIRECT, SPAN_SINGLE, SPAN_DOUBLE, SPAN_TRIPLE, SPAN_BEYOND
  } span_e;

  typedef struct {
    kind_e       kind;
    logic [31:0] lidx;
    logic [31:0] rword;
    logic        rerr;
    logic [3:0]  slot;
    logic [31:0] pval;
  } walk_item_t;

  typedef struct {
    status_e     status;
    logic [31:0] block;
    logic [9:0]  widx;
  } mapping_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i    = LOG2_RESET;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = KIND_NONE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]           m_axis_tuser;

  // stimulus and expectation stores
  walk_item_t  pending_items [$];
  mapping_t    mapping_due [$];
  walk_item_t  in_flight;
  mapping_t    head_map;
  bit          item_loaded = 1'b0;
  int unsigned reads_open  = 0;

  // bench copy of the block state
  logic [31:0]      slot_ptr [SLOT_COUNT];
  logic [CFG_W-1:0] blk_log2       = LOG2_RESET;
  bit               walk_open      = 1'b0;
  logic [1:0]       levels_pending = '0;
  logic [29:0]      offset_rest    = '0;

  int unsigned errors        = 0;
  int unsigned items_done    = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned status_hits [5] = '{default: 0};
  int unsigned tx_gap = 0, tx_calm = 0;
  int unsigned rx_stall = 0, rx_calm = 0;
  int unsigned quiet_cycles = 0;

  indirect_block_map_walker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // effective exponent: out-of-range settings saturate to 8 or 10
  function automatic int unsigned blk_exp(input logic [CFG_W-1:0] v);
    if (v < LOG2_MIN) return LOG2_MIN;
    if (v > LOG2_MAX) return LOG2_MAX;
    return v;
  endfunction

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      calm = $urandom_range(200, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // expected result of one accepted item, updating the bench state
  function automatic void walk_map(input walk_item_t it);
    mapping_t    m;
    int unsigned l;
    int unsigned sh;
    logic [63:0] per;
    logic [63:0] ofs;
    bit          has_result;
    l = blk_exp(blk_log2);
    per = 64'd1 << l;
    m.status = ST_PROTOCOL;
    m.block = '0;
    m.widx = '0;
    has_result = 1'b1;
    case (it.kind)
      KIND_LOAD: begin
        has_result = 1'b0;
        if (it.slot < SLOT_COUNT) slot_ptr[it.slot] = it.pval;
      end
      KIND_LOOKUP: if (!walk_open) begin
        ofs = 64'(it.lidx);
        if (ofs < DIRECT_SLOTS) begin
          m.status = ST_MAPPED;
          m.block = slot_ptr[it.lidx[3:0]];
        end else begin
          ofs -= DIRECT_SLOTS;
          if (ofs < per) begin
            walk_open = 1'b1;
            levels_pending = 2'd0;
            offset_rest = '0;
            m.status = ST_REQUEST;
            m.block = slot_ptr[SLOT_SINGLE];
            m.widx = ofs[9:0];
          end else begin
            ofs -= per;
            if (ofs < per * per) begin
              walk_open = 1'b1;
              levels_pending = 2'd1;
              offset_rest = 30'(ofs & (per - 1));
              m.status = ST_REQUEST;
              m.block = slot_ptr[SLOT_DOUBLE];
              m.widx = 10'(ofs >> l);
            end else begin
              ofs -= per * per;
              if (ofs < per * per * per) begin
                walk_open = 1'b1;
                levels_pending = 2'd2;
                offset_rest = 30'(ofs & (per * per - 1));
                m.status = ST_REQUEST;
                m.block = slot_ptr[SLOT_TRIPLE];
                m.widx = 10'(ofs >> (2 * l));
              end else begin
                m.status = ST_RANGE;
              end
            end
          end
        end
      end
      KIND_DATA: if (walk_open) begin
        if (it.rerr) begin
          walk_open = 1'b0;
          levels_pending = '0;
          offset_rest = '0;
          m.status = ST_FAILED;
        end else if (levels_pending == 0) begin
          walk_open = 1'b0;
          offset_rest = '0;
          m.status = ST_MAPPED;
          m.block = it.rword;
        end else begin
          // two levels left: take the upper offset digit, else the lower one
          sh = (levels_pending == 2) ? l : 0;
          m.status = ST_REQUEST;
          m.block = it.rword;
          m.widx = 10'((64'(offset_rest) >> sh) & (per - 1));
          offset_rest = 30'(64'(offset_rest) & ((64'd1 << sh) - 1));
          levels_pending--;
        end
      end
      default: has_result = 1'b0;
    endcase
    if (has_result) mapping_due.push_back(m);
  endfunction

  // first logical index of a span under the current block size
  function automatic logic [63:0] span_lo(input span_e sp);
    logic [63:0] per;
    per = 64'd1 << blk_exp(blk_log2);
    case (sp)
      SPAN_DIRECT: return 64'd0;
      SPAN_SINGLE: return 64'(DIRECT_SLOTS);
      SPAN_DOUBLE: return 64'(DIRECT_SLOTS) + per;
      SPAN_TRIPLE: return 64'(DIRECT_SLOTS) + per + per * per;
      default:     return 64'(DIRECT_SLOTS) + per + per * per + per * per * per;
    endcase
  endfunction

  // queue an item and track how many reads the open walk still needs
  function automatic void queue_item(input walk_item_t it);
    span_e sp;
    if (it.kind == KIND_LOOKUP && reads_open == 0) begin
      sp = SPAN_BEYOND;
      while (sp != SPAN_DIRECT && 64'(it.lidx) < span_lo(sp)) sp = span_e'(sp - 1);
      if (sp != SPAN_DIRECT && sp != SPAN_BEYOND) reads_open = int'(sp);
    end else if (it.kind == KIND_DATA && reads_open != 0) begin
      reads_open = it.rerr ? 0 : reads_open - 1;
    end
    pending_items.push_back(it);
  endfunction

  // item of the given kind with every field random
  function automatic walk_item_t noise_item(input kind_e k);
    walk_item_t it;
    it.kind = k;
    it.lidx = $urandom;
    it.rword = $urandom;
    it.rerr = 1'($urandom_range(1));
    it.slot = 4'($urandom_range(15));
    it.pval = $urandom;
    return it;
  endfunction

  function automatic void add_lookup(input logic [31:0] idx);
    walk_item_t it;
    it = noise_item(KIND_LOOKUP);
    it.lidx = idx;
    queue_item(it);
  endfunction

  function automatic void add_data(input logic [31:0] word, input logic err);
    walk_item_t it;
    it = noise_item(KIND_DATA);
    it.rword = word;
    it.rerr = err;
    queue_item(it);
  endfunction

  // random item: walks answered with their reads, mixed with noise
  function automatic walk_item_t next_item();
    walk_item_t  it;
    span_e       sp;
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned r;
    r = $urandom_range(99);
    if (reads_open != 0 && r < 90) begin
      it = noise_item(KIND_DATA);
      it.rerr = ($urandom_range(15) == 0);
    end else if (reads_open == 0 && r < 80) begin
      it = noise_item(KIND_LOOKUP);
      r = $urandom_range(99);
      sp = (r < 15) ? SPAN_DIRECT : (r < 35) ? SPAN_SINGLE : (r < 60) ? SPAN_DOUBLE :
           (r < 90) ? SPAN_TRIPLE : SPAN_BEYOND;
      lo = span_lo(sp);
      hi = (sp == SPAN_BEYOND) ? 64'h1_0000_0000 : span_lo(span_e'(sp + 1));
      case ($urandom_range(9))
        0:       it.lidx = 32'(lo);
        1:       it.lidx = 32'(hi - 1);
        default: it.lidx = 32'(lo + {$urandom, $urandom} % (hi - lo));
      endcase
    end else begin
      it = noise_item(kind_e'($urandom_range(3)));
    end
    return it;
  endfunction

  // wait for the queue, the bus and the expectations to empty, then settle
  task automatic drain();
    while (pending_items.size() != 0 || item_loaded || mapping_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        walk_map(in_flight);
        item_loaded = 1'b0;
        items_done++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_flight = pending_items.pop_front();
          item_loaded = 1'b1;
          s_axis_tdata <= {3'b000, in_flight.pval, in_flight.slot, in_flight.rerr,
                           in_flight.rword, in_flight.lidx};
          s_axis_tuser <= in_flight.kind;
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mapping_due.size() == 0) begin
          $error("result with nothing expected: status %0d block %h word %0d",
                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[41:32]);
          errors++;
        end else begin
          head_map = mapping_due.pop_front();
          status_hits[head_map.status]++;
          results_seen++;
          if (m_axis_tuser !== head_map.status) begin
            $error("status: expected %0d, got %0d", head_map.status, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[31:0] !== head_map.block) begin
            $error("block_number: expected %h, got %h", head_map.block, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[41:32] !== head_map.widx) begin
            $error("word_index: expected %0d, got %0d", head_map.widx, m_axis_tdata[41:32]);
            errors++;
          end
        end
      end
      if (rx_stall != 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    walk_item_t it;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every pointer slot, with the extreme values in the first two
    for (int s = 0; s < SLOT_COUNT; s++) begin
      it = noise_item(KIND_LOAD);
      it.slot = 4'(s);
      it.pval = (s == 0) ? 32'h0 : (s == 1) ? 32'hffff_ffff : $urandom;
      queue_item(it);
    end
    // direct hit, single walk with a failed read, double walk with a
    // lookup while busy and an ignored kind, data while idle, out of range
    add_lookup(32'd0);
    add_lookup(32'(span_lo(SPAN_SINGLE)));
    add_data($urandom, 1'b1);
    add_lookup(32'(span_lo(SPAN_DOUBLE)));
    add_lookup(32'(DIRECT_SLOTS - 1));
    queue_item(noise_item(KIND_NONE));
    add_data(32'h0, 1'b0);
    add_data(32'hffff_ffff, 1'b0);
    add_data($urandom, 1'b0);
    add_lookup(32'hffff_ffff);

    // random phases, one per block size setting
    for (int phase = 0; phase <= 8; phase++) begin
      if (phase > 0) begin
        drain();
        @(posedge clk_i);
        cfg_valid_i <= 1'b1;
        cfg_data_i <= (phase < 8) ? BLOCK_EXPS[phase-1] : CFG_W'($urandom_range(15));
        do begin
          @(posedge clk_i);
        end while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
        blk_log2 = cfg_data_i;
        cfg_writes++;
      end
      repeat (ITEMS_PER_PHASE) queue_item(next_item());
    end
    drain();

    $display("covered %0d input transfers and %0d checked results over %0d block size writes",
             items_done, results_seen, cfg_writes);
    $display("results: %0d requests, %0d mapped, %0d out of range, %0d failed, %0d protocol",
             status_hits[ST_REQUEST], status_hits[ST_MAPPED], status_hits[ST_RANGE],
             status_hits[ST_FAILED], status_hits[ST_PROTOCOL]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
